FILE: hdl/spvt_pkg.sv
// Package with the constants, types and arithmetic helpers of the star position and velocity transform.
`timescale 1ns / 1ps

package spvt_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int ANGLE_BITS = 24;
	localparam int ANGLE_DROP = (ANGLE_BITS >= 32) ? 0 :
		((ANGLE_BITS <= 16) ? 16 : 32 - ANGLE_BITS);
	localparam logic [31:0] ANGLE_KEEP = 32'hFFFF_FFFF << ANGLE_DROP;

	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [24:0] K_TRANS = 25'd20358145;
	localparam logic signed [34:0] PCYR = 35'sd4605886126;
	localparam logic [31:0] SPEED_MAX = 32'hFFFF_FFFF;
	localparam logic signed [63:0] POS_MAX = 64'sd549755813887;
	localparam logic signed [63:0] POS_MIN = -64'sd549755813888;

	localparam int SQRT_STEPS = 32;
	localparam int GEO_END = CORDIC_STEPS + 11;
	localparam int SPD_END = SQRT_STEPS + 7;
	localparam int LAST = (GEO_END > SPD_END) ? GEO_END : SPD_END;
	localparam int OUT_STAGE = LAST + 1;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic flip;
	} cord_t;

	typedef struct packed {
		logic [62:0] hi;
		logic [59:0] lo;
		logic neg;
	} prod_t;

	typedef struct packed {
		logic signed [51:0] vx;
		logic signed [51:0] vy;
		logic signed [51:0] vz;
	} vel_t;

	typedef struct packed {
		logic [63:0] s;
		logic [63:0] r;
		logic sat;
	} sqrt_t;

	typedef struct packed {
		logic [39:0] pos_x;
		logic [39:0] pos_y;
		logic [39:0] pos_z;
		logic [39:0] vel_x;
		logic [39:0] vel_y;
		logic [39:0] vel_z;
		logic zero;
	} geo_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h2000_0000;
			5'd1: v = 32'h12E4_051E;
			5'd2: v = 32'h09FB_385B;
			5'd3: v = 32'h0511_11D4;
			5'd4: v = 32'h028B_0D43;
			5'd5: v = 32'h0145_D7E1;
			5'd6: v = 32'h00A2_F61E;
			5'd7: v = 32'h0051_7C55;
			5'd8: v = 32'h0028_BE53;
			5'd9: v = 32'h0014_5F2F;
			5'd10: v = 32'h000A_2F98;
			5'd11: v = 32'h0005_17CC;
			5'd12: v = 32'h0002_8BE6;
			5'd13: v = 32'h0001_45F3;
			5'd14: v = 32'h0000_A2FA;
			5'd15: v = 32'h0000_517D;
			5'd16: v = 32'h0000_28BE;
			5'd17: v = 32'h0000_145F;
			5'd18: v = 32'h0000_0A30;
			5'd19: v = 32'h0000_0518;
			5'd20: v = 32'h0000_028C;
			5'd21: v = 32'h0000_0146;
			5'd22: v = 32'h0000_00A3;
			5'd23: v = 32'h0000_0051;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// Folds the angle into a quarter turn either side of zero.
	function automatic cord_t cord_init(input logic [23:0] ang);
		logic [31:0] a;
		logic signed [33:0] z;
		cord_t c;
		a = {ang, 8'h00} & ANGLE_KEEP;
		z = signed'({{2{a[31]}}, a});
		c.x = CORDIC_X0;
		c.y = '0;
		c.flip = 1'b0;
		if (z > 34'sd1073741824) begin
			z = z - 34'sd2147483648;
			c.flip = 1'b1;
		end else if (z < -34'sd1073741824) begin
			z = z + 34'sd2147483648;
			c.flip = 1'b1;
		end
		c.z = z;
		return c;
	endfunction

	function automatic cord_t cord_step(input cord_t c, input logic [4:0] i);
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] t;
		cord_t r;
		dx = c.y >>> i;
		dy = c.x >>> i;
		t = signed'({2'b00, atan_turn(i) & ANGLE_KEEP});
		r.flip = c.flip;
		if (!c.z[33]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - t;
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + t;
		end
		return r;
	endfunction

	// First half of a rounded product: magnitudes split into two partial products.
	function automatic prod_t pstart(input logic signed [51:0] a, input logic signed [34:0] c,
			input logic sh32);
		logic [51:0] am;
		logic [34:0] cm;
		prod_t p;
		am = a[51] ? unsigned'(-a) : unsigned'(a);
		cm = c[34] ? unsigned'(-c) : unsigned'(c);
		p.hi = am[51:24] * cm;
		p.lo = am[23:0] * cm + (sh32 ? (60'd1 << 31) : (60'd1 << 29));
		p.neg = a[51] ^ c[34];
		return p;
	endfunction

	function automatic logic signed [63:0] pend(input prod_t p, input logic sh32);
		logic [63:0] s;
		logic [63:0] m;
		s = {1'b0, p.hi} + {28'd0, p.lo[59:24]};
		m = sh32 ? (s >> 8) : (s >> 6);
		return p.neg ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic [39:0] sat40(input logic signed [63:0] v);
		logic [39:0] r;
		if (v > POS_MAX) r = 40'h7F_FFFF_FFFF;
		else if (v < POS_MIN) r = 40'h80_0000_0000;
		else r = v[39:0];
		return r;
	endfunction

	function automatic sqrt_t sqrt_step(input sqrt_t a, input logic [4:0] j);
		logic [5:0] sh;
		logic [63:0] b;
		logic [63:0] t;
		sqrt_t n;
		sh = 6'd62 - {j, 1'b0};
		b = 64'd1 << sh;
		t = a.r + b;
		n.sat = a.sat;
		if (a.s >= t) begin
			n.s = a.s - t;
			n.r = (a.r >> 1) + b;
		end else begin
			n.s = a.s;
			n.r = a.r >> 1;
		end
		return n;
	endfunction

endpackage

FILE: hdl/star_position_velocity_transform.sv
// Top level of the star position and velocity transform pipeline.
`timescale 1ns / 1ps

// One star enters per cycle while the output beat is not held up, and its result leaves after the
// chain of CORDIC stages followed by the products of the rotation, or after the 32-step square
// root of the speed, whichever is longer; the two run side by side and the shorter one is padded.
// The whole pipeline holds while the output beat waits, so s_tready follows m_tready whenever the
// output register is full. The configuration register is to be written by the user only while
// no star is in flight; the block itself does not enforce it.
module star_position_velocity_transform import spvt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// right_ascension, declination, distance_pc, pm_ra, pm_dec, radial_velocity
	input logic [151:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, space_speed
	output logic [271:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);

	logic en;
	logic zim_q;
	logic [OUT_STAGE:1] vld_s;

	logic [23:0] ra_in;
	logic [23:0] de_in;
	logic [31:0] dist_in;
	logic signed [23:0] pmra_in;
	logic signed [23:0] pmde_in;
	logic signed [23:0] rv_in;
	logic [23:0] pmag_ra;
	logic [23:0] pmag_de;
	logic [48:0] mk_ra;
	logic [48:0] mk_de;
	logic zero_in;

	cord_t ra_c [0:CORDIC_STEPS];
	cord_t de_c [0:CORDIC_STEPS];
	logic [31:0] dist_c [0:CORDIC_STEPS];
	logic zero_c [0:CORDIC_STEPS];

	logic [47:0] mkra_s1, mkde_s1;
	logic negra_s1, negde_s1;
	logic signed [23:0] rv_s1;
	prod_t py_s2, pz_s2;
	logic signed [31:0] vx_s2;
	vel_t vel_s3;
	vel_t veld [0:CORDIC_STEPS-3];

	logic signed [33:0] cr_g1, sr_g1, cd_g1, sd_g1;
	logic [31:0] dist_g1;
	logic zero_g1;
	vel_t vel_g1;

	prod_t p_crcd_g2, p_srcd_g2, p_dsd_g2, p_vxcd_g2, p_vysd_g2, p_vxsd_g2, p_vycd_g2;
	logic signed [33:0] cr_g2, sr_g2;
	logic [31:0] dist_g2;
	logic zero_g2;
	logic signed [51:0] vz_g2;

	logic signed [33:0] crcd_g3, srcd_g3, cr_g3, sr_g3;
	logic signed [63:0] posy_g3;
	logic signed [51:0] a1_g3, a2_g3, a3_g3, a4_g3, vz_g3;
	logic [31:0] dist_g3;
	logic zero_g3;

	logic signed [51:0] ux_g4, uy_g4, vz_g4;
	prod_t p_dcrcd_g4, p_dsrcd_g4;
	logic signed [63:0] posy_g4;
	logic signed [33:0] cr_g4, sr_g4;
	logic zero_g4;

	logic signed [63:0] posx_g5, posy_g5, posz_g5;
	prod_t p_uxcr_g5, p_vzsr_g5, p_vzcr_g5, p_uxsr_g5, p_uypc_g5;
	logic zero_g5;

	logic signed [51:0] b1_g6, b2_g6, b3_g6, b4_g6;
	logic signed [63:0] vely_g6, posx_g6, posy_g6, posz_g6;
	logic zero_g6;

	logic signed [51:0] wx_g7, wz_g7;
	logic signed [63:0] vely_g7, posx_g7, posy_g7, posz_g7;
	logic zero_g7;

	prod_t p_wxpc_g8, p_wzpc_g8;
	logic signed [63:0] vely_g8, posx_g8, posy_g8, posz_g8;
	logic zero_g8;

	logic signed [63:0] velx_g9, vely_g9, velz_g9, posx_g9, posy_g9, posz_g9;
	logic zero_g9;

	geo_t geo_g10;
	geo_t geo_l;

	logic [51:0] ma, mb, mc;
	logic [52:0] ra_sum, rb_sum, rc_sum;
	logic [31:0] qa_s4, qb_s4, qc_s4;
	logic sat_s4;
	logic [63:0] sqa_s5, sqb_s5, sqc_s5;
	logic sat_s5;
	logic [65:0] sq_sum;
	sqrt_t sq [0:SQRT_STEPS];
	logic [63:0] rr;
	logic [31:0] speed_s39;
	logic [31:0] speed_l;
	logic [271:0] out_q;

	assign en = !vld_s[OUT_STAGE] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[OUT_STAGE];
	assign m_tdata = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			zim_q <= 1'b0;
		end else begin
			if (en) vld_s <= {vld_s[OUT_STAGE-1:1], s_tvalid};
			if (cfg_valid) zim_q <= cfg_data;
		end
	end

	assign ra_in = s_tdata[23:0];
	assign de_in = s_tdata[47:24];
	assign dist_in = s_tdata[79:48];
	assign pmra_in = signed'(s_tdata[103:80]);
	assign pmde_in = signed'(s_tdata[127:104]);
	assign rv_in = signed'(s_tdata[151:128]);
	assign pmag_ra = pmra_in[23] ? unsigned'(-pmra_in) : unsigned'(pmra_in);
	assign pmag_de = pmde_in[23] ? unsigned'(-pmde_in) : unsigned'(pmde_in);
	assign mk_ra = pmag_ra * K_TRANS;
	assign mk_de = pmag_de * K_TRANS;
	assign zero_in = zim_q && (((pmra_in == '0) && (pmde_in == '0)) || (rv_in == '0));

	// Entry stage, transverse velocity and the CORDIC chains.
	always_ff @(posedge clk) begin
		if (en) begin
			ra_c[0] <= cord_init(ra_in);
			de_c[0] <= cord_init(de_in);
			dist_c[0] <= dist_in;
			zero_c[0] <= zero_in;
			mkra_s1 <= mk_ra[47:0];
			mkde_s1 <= mk_de[47:0];
			negra_s1 <= pmra_in[23];
			negde_s1 <= pmde_in[23];
			rv_s1 <= rv_in;

			py_s2 <= pstart(negde_s1 ? -signed'({4'd0, mkde_s1}) : signed'({4'd0, mkde_s1}),
				signed'({3'd0, dist_c[0]}), 1'b1);
			pz_s2 <= pstart(negra_s1 ? signed'({4'd0, mkra_s1}) : -signed'({4'd0, mkra_s1}),
				signed'({3'd0, dist_c[0]}), 1'b1);
			vx_s2 <= signed'({rv_s1, 8'h00});

			vel_s3.vx <= 52'(vx_s2);
			vel_s3.vy <= 52'(pend(py_s2, 1'b1));
			vel_s3.vz <= 52'(pend(pz_s2, 1'b1));
			veld[0] <= vel_s3;
			for (int j = 1; j <= CORDIC_STEPS - 3; j++) veld[j] <= veld[j-1];

			for (int k = 1; k <= CORDIC_STEPS; k++) begin
				ra_c[k] <= cord_step(ra_c[k-1], 5'(k - 1));
				de_c[k] <= cord_step(de_c[k-1], 5'(k - 1));
				dist_c[k] <= dist_c[k-1];
				zero_c[k] <= zero_c[k-1];
			end
		end
	end

	// Position, rotation of the velocity and scaling to parsec per year.
	always_ff @(posedge clk) begin
		if (en) begin
			cr_g1 <= ra_c[CORDIC_STEPS].flip ? -ra_c[CORDIC_STEPS].x : ra_c[CORDIC_STEPS].x;
			sr_g1 <= ra_c[CORDIC_STEPS].flip ? -ra_c[CORDIC_STEPS].y : ra_c[CORDIC_STEPS].y;
			cd_g1 <= de_c[CORDIC_STEPS].flip ? -de_c[CORDIC_STEPS].x : de_c[CORDIC_STEPS].x;
			sd_g1 <= de_c[CORDIC_STEPS].flip ? -de_c[CORDIC_STEPS].y : de_c[CORDIC_STEPS].y;
			dist_g1 <= dist_c[CORDIC_STEPS];
			zero_g1 <= zero_c[CORDIC_STEPS];
			vel_g1 <= veld[CORDIC_STEPS-3];

			p_crcd_g2 <= pstart(52'(cr_g1), 35'(cd_g1), 1'b0);
			p_srcd_g2 <= pstart(52'(sr_g1), 35'(cd_g1), 1'b0);
			p_dsd_g2 <= pstart(signed'({20'd0, dist_g1}), 35'(sd_g1), 1'b0);
			p_vxcd_g2 <= pstart(vel_g1.vx, 35'(cd_g1), 1'b0);
			p_vysd_g2 <= pstart(vel_g1.vy, 35'(sd_g1), 1'b0);
			p_vxsd_g2 <= pstart(vel_g1.vx, 35'(sd_g1), 1'b0);
			p_vycd_g2 <= pstart(vel_g1.vy, 35'(cd_g1), 1'b0);
			cr_g2 <= cr_g1;
			sr_g2 <= sr_g1;
			dist_g2 <= dist_g1;
			zero_g2 <= zero_g1;
			vz_g2 <= vel_g1.vz;

			crcd_g3 <= 34'(pend(p_crcd_g2, 1'b0));
			srcd_g3 <= 34'(pend(p_srcd_g2, 1'b0));
			posy_g3 <= pend(p_dsd_g2, 1'b0);
			a1_g3 <= 52'(pend(p_vxcd_g2, 1'b0));
			a2_g3 <= 52'(pend(p_vysd_g2, 1'b0));
			a3_g3 <= 52'(pend(p_vxsd_g2, 1'b0));
			a4_g3 <= 52'(pend(p_vycd_g2, 1'b0));
			cr_g3 <= cr_g2;
			sr_g3 <= sr_g2;
			dist_g3 <= dist_g2;
			zero_g3 <= zero_g2;
			vz_g3 <= vz_g2;

			ux_g4 <= a1_g3 - a2_g3;
			uy_g4 <= a3_g3 + a4_g3;
			p_dcrcd_g4 <= pstart(signed'({20'd0, dist_g3}), 35'(crcd_g3), 1'b0);
			p_dsrcd_g4 <= pstart(signed'({20'd0, dist_g3}), 35'(srcd_g3), 1'b0);
			posy_g4 <= posy_g3;
			cr_g4 <= cr_g3;
			sr_g4 <= sr_g3;
			zero_g4 <= zero_g3;
			vz_g4 <= vz_g3;

			posx_g5 <= pend(p_dcrcd_g4, 1'b0);
			posz_g5 <= -pend(p_dsrcd_g4, 1'b0);
			posy_g5 <= posy_g4;
			p_uxcr_g5 <= pstart(ux_g4, 35'(cr_g4), 1'b0);
			p_vzsr_g5 <= pstart(vz_g4, 35'(sr_g4), 1'b0);
			p_vzcr_g5 <= pstart(vz_g4, 35'(cr_g4), 1'b0);
			p_uxsr_g5 <= pstart(ux_g4, 35'(sr_g4), 1'b0);
			p_uypc_g5 <= pstart(uy_g4, PCYR, 1'b1);
			zero_g5 <= zero_g4;

			b1_g6 <= 52'(pend(p_uxcr_g5, 1'b0));
			b2_g6 <= 52'(pend(p_vzsr_g5, 1'b0));
			b3_g6 <= 52'(pend(p_vzcr_g5, 1'b0));
			b4_g6 <= 52'(pend(p_uxsr_g5, 1'b0));
			vely_g6 <= pend(p_uypc_g5, 1'b1);
			posx_g6 <= posx_g5;
			posy_g6 <= posy_g5;
			posz_g6 <= posz_g5;
			zero_g6 <= zero_g5;

			wx_g7 <= b1_g6 + b2_g6;
			wz_g7 <= b3_g6 - b4_g6;
			vely_g7 <= vely_g6;
			posx_g7 <= posx_g6;
			posy_g7 <= posy_g6;
			posz_g7 <= posz_g6;
			zero_g7 <= zero_g6;

			p_wxpc_g8 <= pstart(wx_g7, PCYR, 1'b1);
			p_wzpc_g8 <= pstart(wz_g7, PCYR, 1'b1);
			vely_g8 <= vely_g7;
			posx_g8 <= posx_g7;
			posy_g8 <= posy_g7;
			posz_g8 <= posz_g7;
			zero_g8 <= zero_g7;

			velx_g9 <= pend(p_wxpc_g8, 1'b1);
			velz_g9 <= pend(p_wzpc_g8, 1'b1);
			vely_g9 <= vely_g8;
			posx_g9 <= posx_g8;
			posy_g9 <= posy_g8;
			posz_g9 <= posz_g8;
			zero_g9 <= zero_g8;

			geo_g10.pos_x <= sat40(posx_g9);
			geo_g10.pos_y <= sat40(posy_g9);
			geo_g10.pos_z <= sat40(posz_g9);
			geo_g10.vel_x <= sat40(velx_g9);
			geo_g10.vel_y <= sat40(vely_g9);
			geo_g10.vel_z <= sat40(velz_g9);
			geo_g10.zero <= zero_g9;
		end
	end

	// Space speed: rounded components, sum of squares and a digit-by-digit square root.
	assign ma = vel_s3.vx[51] ? unsigned'(-vel_s3.vx) : unsigned'(vel_s3.vx);
	assign mb = vel_s3.vy[51] ? unsigned'(-vel_s3.vy) : unsigned'(vel_s3.vy);
	assign mc = vel_s3.vz[51] ? unsigned'(-vel_s3.vz) : unsigned'(vel_s3.vz);
	assign ra_sum = {1'b0, ma} + 53'd2048;
	assign rb_sum = {1'b0, mb} + 53'd2048;
	assign rc_sum = {1'b0, mc} + 53'd2048;
	assign sq_sum = {2'b00, sqa_s5} + {2'b00, sqb_s5} + {2'b00, sqc_s5};
	assign rr = sq[SQRT_STEPS].r + {63'd0, (sq[SQRT_STEPS].s > sq[SQRT_STEPS].r)};

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s4 <= ra_sum[43:12];
			qb_s4 <= rb_sum[43:12];
			qc_s4 <= rc_sum[43:12];
			sat_s4 <= (ra_sum[52:44] != '0) || (rb_sum[52:44] != '0) || (rc_sum[52:44] != '0);

			sqa_s5 <= qa_s4 * qa_s4;
			sqb_s5 <= qb_s4 * qb_s4;
			sqc_s5 <= qc_s4 * qc_s4;
			sat_s5 <= sat_s4;

			sq[0].s <= sq_sum[63:0];
			sq[0].r <= '0;
			sq[0].sat <= sat_s5 || (sq_sum[65:64] != 2'b00);
			for (int j = 1; j <= SQRT_STEPS; j++) sq[j] <= sqrt_step(sq[j-1], 5'(j - 1));

			speed_s39 <= (sq[SQRT_STEPS].sat || (rr > {32'd0, SPEED_MAX})) ? SPEED_MAX : rr[31:0];
		end
	end

	generate
		if (LAST == GEO_END) begin : g_geo_direct
			assign geo_l = geo_g10;
		end else begin : g_geo_delay
			geo_t geo_dl [LAST-GEO_END];
			always_ff @(posedge clk) begin
				if (en) begin
					geo_dl[0] <= geo_g10;
					for (int i = 1; i < LAST - GEO_END; i++) geo_dl[i] <= geo_dl[i-1];
				end
			end
			assign geo_l = geo_dl[LAST-GEO_END-1];
		end
		if (LAST == SPD_END) begin : g_spd_direct
			assign speed_l = speed_s39;
		end else begin : g_spd_delay
			logic [31:0] spd_dl [LAST-SPD_END];
			always_ff @(posedge clk) begin
				if (en) begin
					spd_dl[0] <= speed_s39;
					for (int i = 1; i < LAST - SPD_END; i++) spd_dl[i] <= spd_dl[i-1];
				end
			end
			assign speed_l = spd_dl[LAST-SPD_END-1];
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			if (geo_l.zero) begin
				out_q <= {32'd0, 40'd0, 40'd0, 40'd0, geo_l.pos_z, geo_l.pos_y, geo_l.pos_x};
			end else begin
				out_q <= {speed_l, geo_l.vel_z, geo_l.vel_y, geo_l.vel_x,
					geo_l.pos_z, geo_l.pos_y, geo_l.pos_x};
			end
		end
	end

endmodule
